// ===== hw/rtl/bpa_pkg.sv =====
// Shared constants, request structs and the buddy-bit position function
// for the buddy page allocator. No dependencies.
package bpa_pkg;

  localparam int PAGE_COUNT  = 4096;
  localparam int ORDER_COUNT = 8;
  localparam int PW = $clog2(PAGE_COUNT);   // page address bits
  localparam int LW = PW + 1;               // link bits, includes empty mark
  localparam int OW = $clog2(ORDER_COUNT);  // order index bits
  localparam logic [LW-1:0] EMPTY_MARK = LW'(PAGE_COUNT);

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_FREE    = 2'd1;
  localparam logic [1:0] ST_ORDER_BIG  = 2'd2;
  localparam logic [1:0] ST_PAGE_RANGE = 2'd3;

  typedef struct packed {
    logic          rd_en;
    logic [PW-1:0] rd_addr;
    logic          nx_we;
    logic [PW-1:0] nx_addr;
    logic [LW-1:0] nx_data;
    logic          pv_we;
    logic [PW-1:0] pv_addr;
    logic [LW-1:0] pv_data;
  } link_req_t;

  typedef struct packed {
    logic          rd_en;
    logic          we;
    logic [PW-1:0] addr;
    logic          wdata;
  } bit_req_t;

  // bits are packed order after order: base(k) = P - (P >> k)
  function automatic logic [PW-1:0] bit_pos(input logic [OW-1:0] k,
                                            input logic [PW-1:0] page);
    logic [LW-1:0] base;
    logic [PW-1:0] offs;
    base = EMPTY_MARK - (EMPTY_MARK >> k);
    offs = page >> ({1'b0, k} + 1'b1);
    return PW'(base + {1'b0, offs});
  endfunction

endpackage

// ===== hw/rtl/bpa_link_store.sv =====
// Per-page next/prev link memories: one shared read address, one write
// port per array, registered read data. Uses bpa_pkg.
module bpa_link_store (
  input  logic                    clk,
  input  bpa_pkg::link_req_t      req,
  output logic [bpa_pkg::LW-1:0]  rd_next,
  output logic [bpa_pkg::LW-1:0]  rd_prev
);
  import bpa_pkg::*;

  logic [LW-1:0] next_mem [PAGE_COUNT];
  logic [LW-1:0] prev_mem [PAGE_COUNT];

  always_ff @(posedge clk) begin
    if (req.nx_we) begin
      next_mem[req.nx_addr] <= req.nx_data;
    end
    if (req.rd_en) begin
      rd_next <= next_mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.pv_we) begin
      prev_mem[req.pv_addr] <= req.pv_data;
    end
    if (req.rd_en) begin
      rd_prev <= prev_mem[req.rd_addr];
    end
  end

endmodule

// ===== hw/rtl/bpa_bit_store.sv =====
// Buddy-bit memory with registered read and a clearing sweep after reset.
// Uses bpa_pkg.
module bpa_bit_store (
  input  logic              clk,
  input  logic              rst,
  input  bpa_pkg::bit_req_t req,
  output logic              rd_bit,
  output logic              busy
);
  import bpa_pkg::*;

  logic          bits [PAGE_COUNT];
  logic [PW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == PW'(PAGE_COUNT - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      bits[clr_addr] <= 1'b0;
    end else if (req.we) begin
      bits[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_bit <= bits[req.addr];
    end
  end

endmodule

// ===== hw/rtl/buddy_page_allocator_unit.sv =====
// Buddy page allocator: one request at a time, sequencer over list heads,
// link memories and a buddy-bit toggle unit. Reject: straight to result load.
// Alloc: scan orders upward (none free: result), pop, toggle buddy bit, then per
// split push the lower half and toggle again. Free: per merge toggle and unlink
// the buddy, then push the final block. Next request taken in the cycle after
// the result loads. Reset: all lists empty, count zero, then a buddy-bit clear.
module buddy_page_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [3:0]  block_order,
  input  logic [11:0] page_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [11:0] block_page,
  output logic [12:0] free_pages
);
  import bpa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_POP, S_FLIP_RD, S_FLIP_WR, S_SPLIT,
    S_PUSH1, S_PUSH2, S_UNLINK, S_FREE_LOOP, S_DONE
  } state_t;

  state_t        state;
  logic          req_op;
  logic [OW-1:0] req_ord;
  logic [OW-1:0] k;          // current order
  logic [PW-1:0] blk;        // current block
  logic          split;      // alloc: flip follows a push
  logic [LW-1:0] nx_save;
  logic [1:0]    res_status;
  logic [PW-1:0] res_page;
  logic [LW-1:0] list_first [ORDER_COUNT];
  logic [LW-1:0] free_count;

  link_req_t     link_req;
  bit_req_t      bit_req;
  logic [LW-1:0] rd_next, rd_prev;
  logic          rd_bit, clr_busy;

  logic [PW-1:0] k_size;     // 1 << k
  logic [LW:0]   fc_add;
  logic [LW-1:0] req_size;

  assign k_size   = PW'(1) << k;
  assign req_size = LW'(1) << req_ord;
  assign fc_add   = {1'b0, free_count} + ({(LW+1){1'b0}} | (LW+1)'(1) << block_order);
  assign in_ready = (state == S_IDLE) && !clr_busy;

  bpa_link_store u_link (
    .clk     (clk),
    .req     (link_req),
    .rd_next (rd_next),
    .rd_prev (rd_prev)
  );

  bpa_bit_store u_bits (
    .clk    (clk),
    .rst    (rst),
    .req    (bit_req),
    .rd_bit (rd_bit),
    .busy   (clr_busy)
  );

  // memory requests per sequencer step
  always_comb begin
    link_req = '0;
    bit_req  = '0;
    bit_req.addr = bit_pos(k, blk);
    case (state)
      S_SCAN: begin
        link_req.rd_en   = list_first[k] < EMPTY_MARK;
        link_req.rd_addr = list_first[k][PW-1:0];
      end
      S_POP: begin
        // new head gets no predecessor
        link_req.pv_we   = rd_next < EMPTY_MARK;
        link_req.pv_addr = rd_next[PW-1:0];
        link_req.pv_data = EMPTY_MARK;
      end
      S_FLIP_RD: begin
        bit_req.rd_en = 1'b1;
      end
      S_FLIP_WR: begin
        bit_req.we    = 1'b1;
        bit_req.wdata = !rd_bit;
        // fetch buddy links in case a merge follows
        link_req.rd_en   = (req_op == OP_FREE);
        link_req.rd_addr = blk ^ k_size;
      end
      S_PUSH1: begin
        link_req.nx_we   = 1'b1;
        link_req.nx_addr = blk;
        link_req.nx_data = list_first[k];
        link_req.pv_we   = 1'b1;
        link_req.pv_addr = blk;
        link_req.pv_data = EMPTY_MARK;
      end
      S_PUSH2: begin
        link_req.pv_we   = 1'b1;
        link_req.pv_addr = nx_save[PW-1:0];
        link_req.pv_data = {1'b0, blk};
      end
      S_UNLINK: begin
        link_req.pv_we   = rd_next < EMPTY_MARK;
        link_req.pv_addr = rd_next[PW-1:0];
        link_req.pv_data = rd_prev;
        link_req.nx_we   = rd_prev < EMPTY_MARK;
        link_req.nx_addr = rd_prev[PW-1:0];
        link_req.nx_data = rd_next;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      free_count <= '0;
      split      <= 1'b0;
      for (int i = 0; i < ORDER_COUNT; i++) begin
        list_first[i] <= EMPTY_MARK;
      end
    end else begin
      // S_DONE only ever raises or holds valid
      if (out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req_op   <= opcode;
            req_ord  <= block_order[OW-1:0];
            k        <= block_order[OW-1:0];
            res_page <= '0;
            split    <= 1'b0;
            if (block_order >= 4'(ORDER_COUNT)) begin
              res_status <= ST_ORDER_BIG;
              state      <= S_DONE;
            end else if (opcode == OP_ALLOC) begin
              state <= S_SCAN;
            end else if ({1'b0, page_index} >= EMPTY_MARK) begin
              res_status <= ST_PAGE_RANGE;
              state      <= S_DONE;
            end else begin
              res_status <= ST_OK;
              free_count <= (fc_add > (LW+1)'(PAGE_COUNT)) ? EMPTY_MARK
                                                          : fc_add[LW-1:0];
              blk   <= page_index & ~((PW'(1) << block_order[OW-1:0]) - 1'b1);
              state <= S_FREE_LOOP;
            end
          end
        end
        S_SCAN: begin
          if (list_first[k] < EMPTY_MARK) begin
            blk   <= list_first[k][PW-1:0];
            state <= S_POP;
          end else if (k == OW'(ORDER_COUNT - 1)) begin
            res_status <= ST_NO_FREE;
            state      <= S_DONE;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_POP: begin
          list_first[k] <= rd_next;
          free_count    <= (free_count >= req_size) ? free_count - req_size : '0;
          res_status    <= ST_OK;
          state         <= S_FLIP_RD;
        end
        S_FLIP_RD: begin
          state <= S_FLIP_WR;
        end
        S_FLIP_WR: begin
          if (req_op == OP_ALLOC) begin
            if (split) begin
              blk <= blk + k_size;
            end
            state <= S_SPLIT;
          end else if (rd_bit) begin
            state <= S_UNLINK;
          end else begin
            state <= S_PUSH1;
          end
        end
        S_SPLIT: begin
          if (k > req_ord) begin
            k     <= k - 1'b1;
            split <= 1'b1;
            state <= S_PUSH1;
          end else begin
            res_page <= blk;
            state    <= S_DONE;
          end
        end
        S_PUSH1: begin
          nx_save       <= list_first[k];
          list_first[k] <= {1'b0, blk};
          if (list_first[k] < EMPTY_MARK) begin
            state <= S_PUSH2;
          end else if (req_op == OP_ALLOC) begin
            state <= S_FLIP_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_PUSH2: begin
          state <= (req_op == OP_ALLOC) ? S_FLIP_RD : S_DONE;
        end
        S_UNLINK: begin
          // buddy was a list head
          if (!(rd_prev < EMPTY_MARK)) begin
            list_first[k] <= rd_next;
          end
          k     <= k + 1'b1;
          blk   <= blk & ~((k_size << 1) - 1'b1);
          state <= S_FREE_LOOP;
        end
        S_FREE_LOOP: begin
          if (({1'b0, k} + 1'b1) < (OW+1)'(ORDER_COUNT)) begin
            state <= S_FLIP_RD;
          end else begin
            state <= S_PUSH1;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            block_page <= 12'(res_page);
            free_pages <= 13'(free_count);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/bpa_checker.sv =====
// Port-level checks for the buddy page allocator, bound to the top level.
// Uses bpa_pkg.
module bpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [11:0] block_page,
  input logic [12:0] free_pages
);
  import bpa_pkg::*;

  // clearing pass keeps the input closed right after reset
  a_reset_closed: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input open right after reset");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while busy");

  a_page_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (block_page == 12'd0))
    else $error("block_page nonzero on failed request");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (free_pages <= 13'(PAGE_COUNT)))
    else $error("free count above pool size");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) &&
    $stable(block_page) && $stable(free_pages)))
    else $error("result changed while stalled");

endmodule

bind buddy_page_allocator_unit bpa_checker u_bpa_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .block_page (block_page),
  .free_pages (free_pages)
);
